FILE: rtl/assert_macros.svh
// Assertion macros for the contrast stretch core.
// Concurrent forms in simulation, empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PCS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PCS_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCS_ASSERT(label, clk, rst_n, prop, msg)
`define PCS_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

FILE: rtl/pcs_pkg.sv
// Shared types and constants for the contrast stretch core.
// No dependencies.
`timescale 1ns / 1ps
package pcs_pkg;
  localparam int CntW = 23;
  localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};
  localparam logic [7:0] FullScale = 8'd255;
  localparam logic OpGather = 1'b0;
  localparam logic OpApply  = 1'b1;
  localparam logic CfgLowIdx  = 1'b0;
  localparam logic CfgHighIdx = 1'b1;
  // floor(x / 100) == (x * Recip100) >> RecipSh for every x below 2^30
  localparam logic [30:0] Recip100 = 31'd1374389535;
  localparam int RecipSh = 37;

  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] inten;
    logic       last;
  } pcs_item_t;

  function automatic logic [6:0] clamp_pct(input logic [6:0] p);
    return (p > 7'd100) ? 7'd100 : p;
  endfunction
endpackage

FILE: rtl/pcs_queue.sv
// Two-entry item queue between front and back of the contrast stretch core.
// Depends on pcs_pkg.
`timescale 1ns / 1ps
module pcs_queue import pcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  pcs_item_t wr_item,
  output logic      full,
  input  logic      rd_en,
  output pcs_item_t rd_item,
  output logic      not_empty
);
  pcs_item_t slot_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slot_r[wp_r] <= wr_item;
  end

  assign rd_item   = slot_r[rp_r];
  assign full      = cnt_r[1];
  assign not_empty = (cnt_r != 2'd0);
endmodule

FILE: rtl/pcs_divider.sv
// Restoring divider, one quotient bit per cycle: 16-bit numerator by 8-bit divisor.
// Depends on pcs_pkg.
`timescale 1ns / 1ps
module pcs_divider import pcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [7:0]  den,
  output logic        busy,
  output logic        done,
  output logic [7:0]  quot
);
  logic [15:0] q_r;
  logic [8:0]  rem_r;
  logic [7:0]  den_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic [8:0]  trial;
  logic        ge;

  assign trial = {rem_r[7:0], q_r[15]};
  assign ge = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= 5'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 5'd16;
      end else if (run_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= 9'd0;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= ge ? trial - {1'b0, den_r} : trial;
      q_r   <= {q_r[14:0], ge};
    end
  end

  assign busy = run_r;
  assign quot = (q_r[15:8] != 8'd0) ? FullScale : q_r[7:0];
endmodule

FILE: rtl/pcs_back.sv
// Back end: histogram memory, bound scan, clear sweep and per-channel stretch.
// Depends on pcs_pkg and pcs_divider.
`timescale 1ns / 1ps
module pcs_back import pcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [6:0]  low_pct,
  input  logic [6:0]  high_pct,
  input  logic        q_valid,
  input  pcs_item_t   q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [7:0]  lower_bound,
  output logic [7:0]  upper_bound,
  output logic        last_pixel,
  output logic        idle
);
  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_GRD   = 10'b0000000100,
    S_GWR   = 10'b0000001000,
    S_CLIP  = 10'b0000010000,
    S_LSCAN = 10'b0000100000,
    S_HSCAN = 10'b0001000000,
    S_CH    = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CntW-1:0] mem [256];
  logic [CntW-1:0] rd_r;
  logic [7:0]  rd_addr, wr_addr;
  logic        wr_en;
  logic [CntW-1:0] wr_data;
  logic [7:0]  addr_r;
  logic [CntW-1:0] total_r;
  logic [7:0]  low_r, high_r;
  pcs_item_t   item_r;
  logic [29:0] prod_r;
  logic [29:0] prod_h_r;
  logic [60:0] lo_quo, hi_quo;
  logic        clip_ph_r;
  logic signed [CntW+1:0] rem_r;
  logic [CntW-1:0] hclip_r;
  logic        rd_ok_r;
  logic [1:0]  ch_r;
  logic [7:0]  res_r [3];
  logic [7:0]  chan;
  logic        dstart, dbusy, ddone;
  logic [7:0]  dq;
  logic signed [CntW+1:0] rem_dec;
  logic [15:0] dnum;
  logic [7:0]  span;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  assign rem_dec = rem_r - $signed({2'b00, rd_r});
  assign chan = (ch_r == 2'd0) ? item_r.red : (ch_r == 2'd1) ? item_r.green : item_r.blue;
  assign span = high_r - low_r;
  assign dnum = (chan - low_r) * 16'd255;
  assign idle = (state_r == S_IDLE);
  assign lo_quo = 61'(prod_r) * 61'(Recip100);
  assign hi_quo = 61'(prod_h_r) * 61'(Recip100);

  always_comb begin
    rd_addr = addr_r;
    if (state_r == S_IDLE) rd_addr = q_item.inten;
    if (state_r == S_GRD) rd_addr = item_r.inten;
    if (state_r == S_LSCAN && rd_ok_r) rd_addr = addr_r + 8'd1;
    if (state_r == S_HSCAN && rd_ok_r) rd_addr = addr_r - 8'd1;
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = '0;
    if (state_r == S_CLEAR) wr_en = 1'b1;
    if (state_r == S_GWR) begin
      wr_en   = 1'b1;
      wr_addr = item_r.inten;
      wr_data = (rd_r == CountMax) ? rd_r : rd_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dstart = 1'b0;
    q_pop = 1'b0;
    case (state_r)
      S_CLEAR: if (addr_r == 8'd255) state_nxt = S_IDLE;
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_nxt = (q_item.op == OpGather) ? S_GRD : S_CH;
        end
      end
      S_GRD:  state_nxt = S_GWR;
      S_GWR:  state_nxt = item_r.last ? S_CLIP : S_IDLE;
      S_CLIP: if (clip_ph_r) state_nxt = S_LSCAN;
      S_LSCAN: begin
        if (rd_ok_r && (rem_dec <= 0 || addr_r == 8'd255)) state_nxt = S_HSCAN;
      end
      S_HSCAN: begin
        if (rd_ok_r && (rem_dec <= 0 || addr_r == 8'd1)) state_nxt = S_IDLE;
      end
      S_CH: begin
        if (chan <= low_r || high_r <= low_r) begin
          if (ch_r == 2'd2) state_nxt = S_OUT;
        end else begin
          dstart = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: if (ddone) state_nxt = (ch_r == 2'd2) ? S_OUT : S_CH;
      S_OUT: if (!out_stall) state_nxt = item_r.last ? S_CLEAR : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r  <= 8'd0;
      total_r <= '0;
      low_r   <= FullScale;
      high_r  <= 8'd0;
      clip_ph_r <= 1'b0;
      rd_ok_r <= 1'b0;
      ch_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_CLEAR: begin
          addr_r <= addr_r + 8'd1;
          total_r <= '0;
        end
        S_IDLE: begin
          if (q_pop) begin
            item_r <= q_item;
            ch_r <= 2'd0;
          end
        end
        S_GWR: begin
          if (total_r != CountMax) total_r <= total_r + 1'b1;
          clip_ph_r <= 1'b0;
        end
        S_CLIP: begin
          clip_ph_r <= ~clip_ph_r;
          if (!clip_ph_r) begin
            prod_r <= 30'(clamp_pct(low_pct)) * 30'(total_r);
            prod_h_r <= 30'(clamp_pct(high_pct)) * 30'(total_r);
          end else begin
            rem_r <= $signed({2'b00, lo_quo[RecipSh +: CntW]});
            hclip_r <= hi_quo[RecipSh +: CntW];
            addr_r <= 8'd0;
            rd_ok_r <= 1'b0;
            low_r <= FullScale;
            high_r <= 8'd0;
          end
        end
        S_LSCAN: begin
          rd_ok_r <= 1'b1;
          if (rd_ok_r) begin
            rem_r <= rem_dec;
            if (rem_dec <= 0 || addr_r == 8'd255) begin
              if (rem_dec <= 0) low_r <= addr_r;
              addr_r <= 8'd255;
              rem_r <= $signed({2'b00, hclip_r});
              rd_ok_r <= 1'b0;
            end else addr_r <= addr_r + 8'd1;
          end
        end
        S_HSCAN: begin
          rd_ok_r <= 1'b1;
          if (rd_ok_r) begin
            rem_r <= rem_dec;
            if (rem_dec <= 0 || addr_r == 8'd1) begin
              if (rem_dec <= 0) high_r <= addr_r;
              addr_r <= 8'd0;
            end else addr_r <= addr_r - 8'd1;
          end
        end
        S_CH: begin
          if (chan <= low_r) begin
            res_r[ch_r] <= 8'd0;
            ch_r <= ch_r + 2'd1;
          end else if (high_r <= low_r) begin
            res_r[ch_r] <= FullScale;
            ch_r <= ch_r + 2'd1;
          end
        end
        S_DIV: begin
          if (ddone) begin
            res_r[ch_r] <= dq;
            if (ch_r != 2'd2) ch_r <= ch_r + 2'd1;
          end
        end
        S_OUT: begin
          if (!out_stall && item_r.last) addr_r <= 8'd0;
        end
        default: ;
      endcase
    end
  end

  pcs_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(span),
    .busy(dbusy), .done(ddone), .quot(dq)
  );

  assign out_valid   = (state_r == S_OUT) && !dbusy;
  assign red_out     = res_r[0];
  assign green_out   = res_r[1];
  assign blue_out    = res_r[2];
  assign lower_bound = low_r;
  assign upper_bound = high_r;
  assign last_pixel  = item_r.last;
endmodule

FILE: rtl/percentile_contrast_stretch_core.sv
// Percentile contrast stretch core: front accepts items into a queue, back runs them.
// Gather: each item reads then bumps its histogram bin; the final one adds clip and bound scan.
// Apply: channels are set directly or sent to the serial divider; then waits on out_stall.
// Reset (rst_n low, synchronous) clears control and bounds; afterwards a clearing pass
// over all 256 bins empties the histogram, and again after each final apply item.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module percentile_contrast_stretch_core import pcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  input  logic [7:0] in_intensity_in,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic [7:0] out_lower_bound,
  output logic [7:0] out_upper_bound,
  output logic       out_last_pixel,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [6:0] cfg_data
);
  logic [6:0] low_pct_r, high_pct_r;
  pcs_item_t in_item, q_item;
  logic q_full, q_ne, q_pop, wr_en, back_idle;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_pct_r  <= 7'd0;
      high_pct_r <= 7'd0;
    end else if (cfg_valid) begin
      if (cfg_index == CfgLowIdx) low_pct_r <= cfg_data;
      if (cfg_index == CfgHighIdx) high_pct_r <= cfg_data;
    end
  end

  assign in_item = '{op: in_opcode, red: in_red_in, green: in_green_in,
                     blue: in_blue_in, inten: in_intensity_in, last: in_frame_end};
  assign in_stall = q_full;
  assign wr_en = in_valid && !q_full;

  pcs_queue u_q (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_item(in_item), .full(q_full),
    .rd_en(q_pop), .rd_item(q_item), .not_empty(q_ne)
  );

  pcs_back u_back (
    .clk(clk), .rst_n(rst_n), .low_pct(low_pct_r), .high_pct(high_pct_r),
    .q_valid(q_ne), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .red_out(out_red_out), .green_out(out_green_out), .blue_out(out_blue_out),
    .lower_bound(out_lower_bound), .upper_bound(out_upper_bound),
    .last_pixel(out_last_pixel), .idle(back_idle)
  );

  `PCS_ASSERT(a_pop_nonempty, clk, rst_n, q_pop |-> q_ne, "pop from empty queue")
  `PCS_ASSERT(a_pop_idle, clk, rst_n, q_pop |-> back_idle, "pop while back end busy")
  `PCS_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid, "result dropped")
endmodule
